FILE: rtl/core/speq_pkg.sv
package speq_pkg;

   localparam int CAPACITY      = 16;
   localparam int PRIORITY_BITS = 8;

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int OCC_W  = 5;
   localparam int PRIO_W = 8;

   // only the low PRIORITY_BITS of a priority take part in ordering
   localparam logic [PRIO_W-1:0] PRIO_MASK = (PRIORITY_BITS >= PRIO_W) ?
      {PRIO_W{1'b1}} : PRIO_W'((64'd1 << PRIORITY_BITS) - 64'd1);

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   typedef struct packed {
      logic              command;
      logic [3:0]        system_id;
      logic [3:0]        resource_id;
      logic [3:0]        event_status;
      logic [PRIO_W-1:0] priority_req;
      logic [15:0]       amount;
   } req_type;

   typedef struct packed {
      logic              pop_valid;
      logic [3:0]        out_system_id;
      logic [3:0]        out_resource_id;
      logic [3:0]        out_status;
      logic [PRIO_W-1:0] out_priority;
      logic [15:0]       out_amount;
      logic              overflow;
      logic [OCC_W-1:0]  occupancy;
   } rsp_type;

   typedef struct packed {
      logic [3:0]        system_id;
      logic [3:0]        resource_id;
      logic [3:0]        event_status;
      logic [PRIO_W-1:0] priority_val;
      logic [15:0]       amount;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic do_push;
      logic do_pop;
      logic drop;
      logic respond;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_pop;
      logic full;
      logic empty;
   } dp_status_type;

endpackage

FILE: rtl/core/speq_ctrl.sv
module speq_ctrl
   import speq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.do_push = !status.is_pop && !status.full;
            cmd.drop    = !status.is_pop && status.full;
            cmd.do_pop  = status.is_pop && !status.empty;
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff == ST_EXEC);

endmodule

FILE: rtl/core/speq_datapath.sv
module speq_datapath
   import speq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_data,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output logic          rsp_strobe,
   output rsp_type       rsp_data
);

   req_type          req_ff;
   entry_type        cell_ff [CAPACITY];
   entry_type        cell_in [CAPACITY];
   logic [CNT_W-1:0] count_ff, count_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_strobe_ff;
   logic [CAPACITY-1:0] keep;
   entry_type        new_entry;

   assign new_entry.system_id    = req_ff.system_id;
   assign new_entry.resource_id  = req_ff.resource_id;
   assign new_entry.event_status = req_ff.event_status;
   assign new_entry.priority_val = req_ff.priority_req & PRIO_MASK;
   assign new_entry.amount       = req_ff.amount;

   // a cell holds its entry when it is occupied and ranks at or above the
   // new entry; the sorted order makes this a thermometer code
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         keep[i] = (CNT_W'(i) < count_ff) &&
                   (cell_ff[i].priority_val >= new_entry.priority_val);
      end
   end

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cell_in[i] = cell_ff[i];
      end
      if (cmd.do_push) begin
         if (!keep[0]) begin
            cell_in[0] = new_entry;
         end
         for (int i = 1; i < CAPACITY; i++) begin
            if (!keep[i]) begin
               if (keep[i-1]) begin
                  cell_in[i] = new_entry;
               end else begin
                  cell_in[i] = cell_ff[i-1];
               end
            end
         end
      end else if (cmd.do_pop) begin
         for (int i = 0; i < CAPACITY - 1; i++) begin
            cell_in[i] = cell_ff[i+1];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.do_push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_in           = '0;
      rsp_in.overflow  = cmd.drop;
      rsp_in.occupancy = OCC_W'(count_in);
      if (cmd.do_pop) begin
         rsp_in.pop_valid       = 1'b1;
         rsp_in.out_system_id   = cell_ff[0].system_id;
         rsp_in.out_resource_id = cell_ff[0].resource_id;
         rsp_in.out_status      = cell_ff[0].event_status;
         rsp_in.out_priority    = cell_ff[0].priority_val;
         rsp_in.out_amount      = cell_ff[0].amount;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.respond) begin
         rsp_ff <= rsp_in;
      end
      for (int i = 0; i < CAPACITY; i++) begin
         cell_ff[i] <= cell_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= cmd.respond;
      end
   end

   assign status.is_pop = (req_ff.command == CMD_POP);
   assign status.full   = (count_ff == CNT_W'(CAPACITY));
   assign status.empty  = (count_ff == '0);
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_data      = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_pop_no_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_ff.pop_valid |-> !rsp_ff.overflow)
      else $error("pop result flagged overflow");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.do_push |=> count_ff == CNT_W'($past(count_ff) + CNT_W'(1)))
      else $error("push did not grow the count");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.do_pop |-> count_ff != '0)
      else $error("pop issued on empty queue");

   a_one_op: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.do_push, cmd.do_pop, cmd.drop}) <= 1)
      else $error("conflicting datapath commands");

endmodule

FILE: rtl/core/stable_priority_event_queue_top.sv
// Channel      Ports                       Transfer rule
// request      start, busy, req_data       taken at a clock edge with start high, busy low
// response     rsp_strobe, rsp_data        valid for the single cycle rsp_strobe is high
//
// Each transaction is captured, then executed: in execute the whole sorted
// cell row shifts or inserts at once, or holds on a drop or an empty pop,
// and busy is high. The response strobes in the cycle after execute, and a
// new request may be taken in that same cycle.
// Reset (synchronous, active high) empties the queue; cell contents are not
// cleared, only the entry count. The receiver cannot stall the response.
module stable_priority_event_queue_top
   import speq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequence capture and execute, pick push, drop or pop from queue status
   speq_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // hold the sorted entries and build the registered response
   speq_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
   import speq_pkg::*;

   // Ends the run if the queue hangs. The slowest correct run needs a capture
   // and an execute per transaction plus a random gap between bursts, so the
   // whole stimulus stays far below this limit.
   localparam int CYCLE_LIMIT  = 200_000;
   localparam int RANDOM_ITEMS = 1150;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   int unsigned cycle_count = 0;

   // Scoreboard: mirrors the sorted queue and holds the responses that
   // are still owed by the block, oldest first.
   class queue_checker;
      entry_type held[$];
      rsp_type   pending_results[$];
      int        failures = 0;

      // Apply one accepted transaction to the mirror, queue its response.
      function void note_request(req_type r);
         rsp_type   res;
         entry_type ev;
         int        pos;
         res = '0;
         if (r.command == CMD_PUSH) begin
            if (held.size() >= CAPACITY) begin
               res.overflow = 1'b1;
            end else begin
               ev.system_id    = r.system_id;
               ev.resource_id  = r.resource_id;
               ev.event_status = r.event_status;
               ev.priority_val = r.priority_req & PRIO_MASK;
               ev.amount       = r.amount;
               // insert behind every entry of equal or higher priority
               pos = 0;
               while (pos < held.size() && held[pos].priority_val >= ev.priority_val)
                  pos++;
               held.insert(pos, ev);
            end
         end else if (held.size() > 0) begin
            ev = held.pop_front();
            res.pop_valid       = 1'b1;
            res.out_system_id   = ev.system_id;
            res.out_resource_id = ev.resource_id;
            res.out_status      = ev.event_status;
            res.out_priority    = ev.priority_val;
            res.out_amount      = ev.amount;
         end
         res.occupancy = OCC_W'(held.size());
         pending_results.push_back(res);
      endfunction

      function void check_field(string name, longint unsigned exp_val,
                                longint unsigned act_val);
         if (exp_val != act_val) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
            failures++;
         end
      endfunction

      // Compare one strobed response against the oldest owed response.
      function void check_response(rsp_type r);
         rsp_type exp_rsp;
         if (pending_results.size() == 0) begin
            $error("response strobed with no transaction outstanding");
            failures++;
            return;
         end
         exp_rsp = pending_results.pop_front();
         check_field("pop_valid",       exp_rsp.pop_valid,       r.pop_valid);
         check_field("out_system_id",   exp_rsp.out_system_id,   r.out_system_id);
         check_field("out_resource_id", exp_rsp.out_resource_id, r.out_resource_id);
         check_field("out_status",      exp_rsp.out_status,      r.out_status);
         check_field("out_priority",    exp_rsp.out_priority,    r.out_priority);
         check_field("out_amount",      exp_rsp.out_amount,      r.out_amount);
         check_field("overflow",        exp_rsp.overflow,        r.overflow);
         check_field("occupancy",       exp_rsp.occupancy,       r.occupancy);
      endfunction
   endclass

   queue_checker sb;

   stable_priority_event_queue_top dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Sample at the rising edge: check the response first, then record the
   // transaction taken at this same edge. Both see pre-edge values.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe)
            sb.check_response(rsp_data);
         if (start && !busy)
            sb.note_request(req_data);
      end
   end

   // Watchdog: bail out if the run never drains.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   function automatic req_type build_event(logic cmd, logic [3:0] sys_id,
                                           logic [3:0] res_id, logic [3:0] status,
                                           logic [PRIO_W-1:0] prio, logic [15:0] amt);
      req_type r;
      r.command      = cmd;
      r.system_id    = sys_id;
      r.resource_id  = res_id;
      r.event_status = status;
      r.priority_req = prio;
      r.amount       = amt;
      return r;
   endfunction

   // Random payload around a chosen command and priority; pops carry
   // junk payload too, which the block must ignore.
   function automatic req_type random_event(logic cmd, logic [PRIO_W-1:0] prio);
      return build_event(cmd, 4'($urandom), 4'($urandom), 4'($urandom), prio,
                         16'($urandom));
   endfunction

   // Present one transaction at the falling edge, hold it until taken.
   task automatic send_event(input req_type r);
      @(negedge clock);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
   endtask

   // Drop start and toggle junk on the payload while it is low.
   task automatic hold_off(input int n);
      repeat (n) begin
         @(negedge clock);
         start    <= 1'b0;
         req_data <= random_event(1'($urandom), PRIO_W'($urandom));
      end
   endtask

   // Pick a priority: full range, a tight cluster to force ties,
   // the two extremes, or a narrow band in the middle.
   function automatic logic [PRIO_W-1:0] pick_priority(int mode);
      case (mode)
         0: return PRIO_W'($urandom_range(0, 255));
         1: return PRIO_W'($urandom_range(0, 3));
         2: return ($urandom_range(0, 1) == 0) ? PRIO_W'(0) : PRIO_W'(255);
         default: return PRIO_W'($urandom_range(100, 103));
      endcase
   endfunction

   initial begin
      int unsigned       sent;
      int                burst_len;
      int                push_pct;
      int                prio_mode;
      logic              cmd;
      logic [PRIO_W-1:0] fill_prio [13];

      sb       = new;
      fill_prio = '{128, 128, 128, 255, 0, 1, 254, 128, 127, 129, 64, 200, 7};
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: pop from an empty queue.
      send_event(build_event(CMD_POP, 4'h0, 4'h0, 4'h0, 8'h00, 16'h0000));
      // Extremes of every field.
      send_event(build_event(CMD_PUSH, 4'h0, 4'h0, 4'h0, 8'h00, 16'h0000));
      send_event(build_event(CMD_PUSH, 4'hF, 4'hF, 4'hF, 8'hFF, 16'hFFFF));
      // Fill the queue: ties at 128, 255 and 0 must leave in arrival order.
      for (int i = 0; i < 13; i++)
         send_event(build_event(CMD_PUSH, 4'(i + 1), 4'(15 - i), 4'(i), fill_prio[i],
                                16'(i * 4099)));
      send_event(build_event(CMD_PUSH, 4'h9, 4'h6, 4'hA, 8'd128, 16'h5A5A));
      // Push into a full queue: dropped, overflow raised.
      send_event(build_event(CMD_PUSH, 4'hF, 4'hF, 4'hF, 8'hFF, 16'hFFFF));
      send_event(build_event(CMD_PUSH, 4'h1, 4'h2, 4'h3, 8'h00, 16'h1234));
      // Pop from full, then refill one slot behind equal priority.
      send_event(build_event(CMD_POP, 4'hF, 4'hF, 4'hF, 8'hFF, 16'hFFFF));
      send_event(build_event(CMD_POP, 4'h0, 4'h0, 4'h0, 8'h00, 16'h0000));
      send_event(build_event(CMD_PUSH, 4'hC, 4'h3, 4'h5, 8'd128, 16'hBEEF));
      send_event(build_event(CMD_POP, 4'h0, 4'h0, 4'h0, 8'h00, 16'h0000));

      // Random: bursts with a push bias per burst so the queue swings
      // between full and empty, then a random gap or none at all.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst_len = $urandom_range(1, 24);
         case ($urandom_range(0, 3))
            0: push_pct = 85;
            1: push_pct = 15;
            default: push_pct = 50;
         endcase
         prio_mode = $urandom_range(0, 3);
         repeat (burst_len) begin
            cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
            send_event(random_event(cmd, pick_priority(prio_mode)));
            sent++;
         end
         if ($urandom_range(0, 3) != 0)
            hold_off($urandom_range(1, 6));
      end

      // Drain: release start and wait for every owed response.
      @(negedge clock);
      start <= 1'b0;
      while (sb.pending_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);

      if (sb.failures == 0 && sb.pending_results.size() == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
